// ===== rtl/afsk_correlator_uart_demodulator_assert.svh =====
// Assertion macros shared by the checker of the AFSK demodulator.
// Depends on nothing; every macro samples on the rising edge of clock.
`ifndef AFSK_CORRELATOR_UART_DEMODULATOR_ASSERT_SVH
`define AFSK_CORRELATOR_UART_DEMODULATOR_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define ACUD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ACUD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== rtl/acud_pkg.sv =====
// Package of the AFSK correlator demodulator: widths, register indexes,
// controller states, command structs and the reference-tone coefficient ROM.
package acud_pkg;

   // Default build parameters.
   localparam int TAPS_DEF        = 8;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int COEF_BITS_DEF   = 16;

   // Correlator sums are cut to Q3.15 before squaring.
   localparam int ACC_BITS    = 18;
   localparam int ACC_FRAC    = 15;
   localparam int ENERGY_BITS = 2 * ACC_BITS + 2;
   localparam int TABLE_TAPS  = 8;

   // Bit clock and framer.
   localparam int PHASE_BITS  = 16;
   localparam int NUDGE_BITS  = 15;
   localparam int FRAME_BITS  = 11;
   localparam int BYTE_BITS   = 8;
   localparam logic [PHASE_BITS-1:0] PHASE_INC_RESET   = 16'd14153;
   localparam logic [NUDGE_BITS-1:0] PHASE_NUDGE_RESET = 15'd1769;
   localparam logic [PHASE_BITS:0]   PHASE_HALF        = 17'h08000;
   localparam logic [FRAME_BITS-1:0] FRAME_TOP         = 11'h400;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_PHASE_INC   = 1'b0,
      REG_PHASE_NUDGE = 1'b1
   } csr_reg_type;

   // Correlator references, in the order mark cos, mark sin, space cos, space sin.
   localparam int NUM_CORR = 4;
   typedef enum logic [1:0] {
      CORR_MARK_COS  = 2'd0,
      CORR_MARK_SIN  = 2'd1,
      CORR_SPACE_COS = 2'd2,
      CORR_SPACE_SIN = 2'd3
   } corr_type;

   localparam int COEF_TAB [NUM_CORR][TABLE_TAPS] = '{
      '{  2621,  1761, -19153, -18717,  20513,  18457, -2354, -2614 },
      '{     0,  8108,   8731, -25056, -23608,  10119,  7956,  -193 },
      '{  2621,  6459,   4467, -14014, -28458, -20391, -4965,    97 },
      '{     0,  5207,  20569,  27960,  12973,  -5223, -6647, -2620 }
   };

   // Coefficient of reference k at tap i, rescaled from Q1.15 to bits wide,
   // truncated toward zero when narrower. Taps past the table are zero.
   function automatic int coef_scaled(input logic [1:0] k, input int i, input int bits);
      int c;
      logic [2:0] idx;
      idx = i[2:0];
      if (i >= TABLE_TAPS) begin
         return 0;
      end
      c = COEF_TAB[k][idx];
      if (bits >= 16) begin
         return c <<< (bits - 16);
      end
      if (c < 0) begin
         return -((-c) >>> (16 - bits));
      end
      return c >>> (16 - bits);
   endfunction

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_MAC,
      ST_DRAIN,
      ST_SAT,
      ST_SQUARE,
      ST_ENERGY,
      ST_DECIDE
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic     load;      // shift the accepted sample into the window
      logic     en_clear;  // clear the energy difference
      logic     acc_clear; // clear the correlation sum and product
      logic     mul_en;    // capture a product
      logic     square;    // multiplier squares the saturated sum
      logic     acc_add;   // add the product into the correlation sum
      logic     sat_en;    // capture the cut and saturated sum
      logic     en_add;    // fold the square into the energy difference
      corr_type corr;      // reference being correlated
      logic     commit;    // tone decision, bit clock and framer update
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;      // result register can take a byte this cycle
   } dp_status_type;

endpackage

// ===== rtl/acud_sample_if.sv =====
// Stream interface carrying one signed audio sample per beat.
// Depends on acud_pkg for the default sample width.
interface acud_sample_if #(
   parameter int SAMPLE_BITS = acud_pkg::SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// ===== rtl/acud_byte_if.sv =====
// Stream interface carrying one received data byte per beat.
// Depends on acud_pkg for the byte width.
interface acud_byte_if;
   logic                             valid;
   logic                             ready;
   logic [acud_pkg::BYTE_BITS-1:0]   rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/afsk_correlator_uart_demodulator.sv =====
// AFSK demodulator: one signed audio sample per req beat, one received byte per
// rsp beat whenever a start/stop frame completes. Samples are taken one at a time:
// a new beat is accepted only once one shared multiplier has computed, for each of
// the four references in turn, every tap product and then the square. The decision
// step waits as long as the previous byte sits untaken in the result register,
// whether or not this sample completes a byte. Registers are to be written over
// csr_ only while idle; the block itself does not enforce this.
module afsk_correlator_uart_demodulator #(
   parameter int TAPS        = acud_pkg::TAPS_DEF,
   parameter int SAMPLE_BITS = acud_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = acud_pkg::COEF_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   acud_sample_if.sink                          req_if,
   acud_byte_if.source                          rsp_if,
   input  logic                                 csr_we,
   input  logic [acud_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [acud_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   acud_pkg::dp_cmd_type          cmd;
   acud_pkg::dp_status_type       status;
   logic [$clog2(TAPS)-1:0]       tap_idx;
   logic signed [SAMPLE_BITS-1:0] sample;

   assign sample = req_if.sample;

   // Sequencer.
   acud_ctrl #(
      .TAPS (TAPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd),
      .tap_idx   (tap_idx)
   );

   // Arithmetic, bit clock and framer.
   acud_datapath #(
      .TAPS        (TAPS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .tap_idx   (tap_idx),
      .status    (status),
      .sample    (sample),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .rsp_byte  (rsp_if.rx_byte)
   );

endmodule

// ===== rtl/acud_ctrl.sv =====
// Sequencer of the demodulator: walks the shared multiplier over every tap of
// each reference followed by its square, then the decision. Uses acud_pkg.
module acud_ctrl #(
   parameter int TAPS = acud_pkg::TAPS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  acud_pkg::dp_status_type      status,
   output acud_pkg::dp_cmd_type         cmd,
   output logic [$clog2(TAPS)-1:0]      tap_idx
);
   localparam int TW = $clog2(TAPS);
   localparam logic [TW-1:0] TAP_LAST = TW'(TAPS - 1);

   acud_pkg::ctrl_state_type state_ff, state_in;
   logic [TW-1:0]            tap_ff, tap_in;
   acud_pkg::corr_type       corr_ff, corr_in;

   // State and counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= acud_pkg::ST_IDLE;
         tap_ff   <= '0;
         corr_ff  <= acud_pkg::CORR_MARK_COS;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
         corr_ff  <= corr_in;
      end
   end

   // Next state: four correlations in turn, then one decision.
   always_comb begin
      state_in = state_ff;
      tap_in   = tap_ff;
      corr_in  = corr_ff;
      case (state_ff)
         acud_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = acud_pkg::ST_CLEAR;
               corr_in  = acud_pkg::CORR_MARK_COS;
            end
         end
         acud_pkg::ST_CLEAR: begin
            state_in = acud_pkg::ST_MAC;
            tap_in   = '0;
         end
         acud_pkg::ST_MAC: begin
            if (tap_ff == TAP_LAST) begin
               state_in = acud_pkg::ST_DRAIN;
            end else begin
               tap_in = tap_ff + 1'b1;
            end
         end
         acud_pkg::ST_DRAIN:  state_in = acud_pkg::ST_SAT;
         acud_pkg::ST_SAT:    state_in = acud_pkg::ST_SQUARE;
         acud_pkg::ST_SQUARE: state_in = acud_pkg::ST_ENERGY;
         acud_pkg::ST_ENERGY: begin
            if (corr_ff == acud_pkg::CORR_SPACE_SIN) begin
               state_in = acud_pkg::ST_DECIDE;
            end else begin
               state_in = acud_pkg::ST_CLEAR;
               corr_in  = acud_pkg::corr_type'(corr_ff + 2'd1);
            end
         end
         acud_pkg::ST_DECIDE: begin
            if (status.out_free) begin
               state_in = acud_pkg::ST_IDLE;
            end
         end
         default: state_in = acud_pkg::ST_IDLE;
      endcase
   end

   // Commands for the current state.
   always_comb begin
      cmd       = '0;
      cmd.corr  = corr_ff;
      tap_idx   = tap_ff;
      req_ready = 1'b0;
      case (state_ff)
         acud_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load     = req_valid;
            cmd.en_clear = req_valid;
         end
         acud_pkg::ST_CLEAR:  cmd.acc_clear = 1'b1;
         acud_pkg::ST_MAC: begin
            cmd.mul_en  = 1'b1;
            cmd.acc_add = 1'b1;
         end
         acud_pkg::ST_DRAIN:  cmd.acc_add = 1'b1;
         acud_pkg::ST_SAT:    cmd.sat_en  = 1'b1;
         acud_pkg::ST_SQUARE: begin
            cmd.mul_en = 1'b1;
            cmd.square = 1'b1;
         end
         acud_pkg::ST_ENERGY: cmd.en_add = 1'b1;
         acud_pkg::ST_DECIDE: cmd.commit = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

// ===== rtl/acud_datapath.sv =====
// Datapath of the demodulator: sample window, shared multiplier, correlation
// and energy accumulators, bit clock, framer, result register. Uses acud_pkg.
module acud_datapath #(
   parameter int TAPS        = acud_pkg::TAPS_DEF,
   parameter int SAMPLE_BITS = acud_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = acud_pkg::COEF_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  acud_pkg::dp_cmd_type                 cmd,
   input  logic [$clog2(TAPS)-1:0]              tap_idx,
   output acud_pkg::dp_status_type              status,
   input  logic signed [SAMPLE_BITS-1:0]        sample,
   input  logic                                 csr_we,
   input  logic [acud_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [acud_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [acud_pkg::BYTE_BITS-1:0]       rsp_byte
);
   localparam int AB  = acud_pkg::ACC_BITS;
   localparam int MA  = (SAMPLE_BITS > AB) ? SAMPLE_BITS : AB;
   localparam int MB  = (COEF_BITS > AB) ? COEF_BITS : AB;
   localparam int PW  = MA + MB;
   localparam int SW  = PW + $clog2(TAPS);
   localparam int EB  = acud_pkg::ENERGY_BITS;
   localparam int SH  = SAMPLE_BITS + COEF_BITS - 2 - acud_pkg::ACC_FRAC;
   localparam int SHR = (SH > 0) ? SH : 0;
   localparam int SHL = (SH < 0) ? -SH : 0;
   localparam int PB  = acud_pkg::PHASE_BITS;
   localparam int PX  = PB + 3;
   localparam int FB  = acud_pkg::FRAME_BITS;
   localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (AB - 1)) - 64'sd1);
   localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

   logic signed [SAMPLE_BITS-1:0] win_ff [TAPS];
   logic signed [PW-1:0]          prod_ff;
   logic signed [SW-1:0]          sum_ff;
   logic signed [AB-1:0]          sat_ff;
   logic signed [EB-1:0]          en_ff;
   logic [PB-1:0]                 inc_ff;
   logic [acud_pkg::NUDGE_BITS-1:0] nudge_ff;
   logic [PB-1:0]                 phase_ff, phase_in;
   logic                          last_tone_ff;
   logic [FB-1:0]                 frame_ff, frame_in;
   logic                          rsp_valid_ff;
   logic [acud_pkg::BYTE_BITS-1:0] rsp_byte_ff;

   logic signed [COEF_BITS-1:0]   coef;
   logic signed [MA-1:0]          mul_a;
   logic signed [MB-1:0]          mul_b;
   logic signed [PW-1:0]          product;
   logic signed [SW-1:0]          shifted;
   logic signed [SW-1:0]          clipped;
   logic signed [EB-1:0]          square_ext;
   logic                          tone;
   logic                          tone_edge;
   logic [PB:0]                   threshold;
   logic [PX-1:0]                 p_nudged;
   logic [PX-1:0]                 p_sum;
   logic                          wrap;
   logic                          emit;
   logic [FB-1:0]                 frame_mid;

   // Sample window, oldest sample at index zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAPS; i++) begin
            win_ff[i] <= '0;
         end
      end else if (cmd.load) begin
         for (int i = 0; i < TAPS - 1; i++) begin
            win_ff[i] <= win_ff[i + 1];
         end
         win_ff[TAPS - 1] <= sample;
      end
   end

   // Shared multiplier: tap products, then the square of the cut sum.
   assign coef    = COEF_BITS'(acud_pkg::coef_scaled(cmd.corr, int'(tap_idx), COEF_BITS));
   assign mul_a   = cmd.square ? MA'(sat_ff) : MA'(win_ff[tap_idx]);
   assign mul_b   = cmd.square ? MB'(sat_ff) : MB'(coef);
   assign product = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (cmd.acc_clear) begin
         prod_ff <= '0;
      end else if (cmd.mul_en) begin
         prod_ff <= product;
      end
   end

   // Correlation sum; the add works on the product registered in the cycle before.
   always_ff @(posedge clock) begin
      if (cmd.acc_clear) begin
         sum_ff <= '0;
      end else if (cmd.acc_add) begin
         sum_ff <= sum_ff + SW'(prod_ff);
      end
   end

   // Cut to Q3.15 with a flooring shift, then saturate to 18 bits.
   assign shifted = (sum_ff >>> SHR) <<< SHL;
   always_comb begin
      clipped = shifted;
      if (shifted > SAT_HI) begin
         clipped = SAT_HI;
      end else if (shifted < SAT_LO) begin
         clipped = SAT_LO;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sat_en) begin
         sat_ff <= AB'(clipped);
      end
   end

   // Mark energy minus space energy.
   assign square_ext = EB'(prod_ff);
   always_ff @(posedge clock) begin
      if (cmd.en_clear) begin
         en_ff <= '0;
      end else if (cmd.en_add) begin
         if (cmd.corr[1]) begin
            en_ff <= en_ff - square_ext;
         end else begin
            en_ff <= en_ff + square_ext;
         end
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         inc_ff   <= acud_pkg::PHASE_INC_RESET;
         nudge_ff <= acud_pkg::PHASE_NUDGE_RESET;
      end else if (csr_we) begin
         case (acud_pkg::csr_reg_type'(csr_index))
            acud_pkg::REG_PHASE_INC:   inc_ff   <= csr_wdata[PB-1:0];
            acud_pkg::REG_PHASE_NUDGE: nudge_ff <= csr_wdata[acud_pkg::NUDGE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Tone decision and bit clock. The phase sum is kept in 19 bits so that
   // both an overflow past 0xffff and a dip below zero show in the top bits.
   assign tone      = (en_ff > EB'(0));
   assign tone_edge = tone ^ last_tone_ff;
   assign threshold = acud_pkg::PHASE_HALF - {2'b00, inc_ff[PB-1:1]};

   always_comb begin
      p_nudged = PX'(phase_ff);
      if (tone_edge) begin
         if ({1'b0, phase_ff} < threshold) begin
            p_nudged = PX'(phase_ff) + PX'(nudge_ff);
         end else begin
            p_nudged = PX'(phase_ff) - PX'(nudge_ff);
         end
      end
   end

   assign p_sum    = p_nudged + PX'(inc_ff);
   assign wrap     = |p_sum[PX-1:PB];
   assign phase_in = p_sum[PB-1:0];

   // Start/stop framer; the sampled data bit is the inverted tone.
   always_comb begin
      emit      = 1'b0;
      frame_mid = frame_ff;
      if (!tone) begin
         if (frame_ff[0] && !frame_ff[1]) begin
            emit      = 1'b1;
            frame_mid = acud_pkg::FRAME_TOP;
         end else begin
            frame_mid = frame_ff | acud_pkg::FRAME_TOP;
         end
      end
      if (frame_mid[0]) begin
         frame_mid[1] = 1'b1;
      end
      frame_in = frame_mid >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         last_tone_ff <= 1'b0;
         frame_ff     <= '0;
      end else if (cmd.commit) begin
         phase_ff     <= phase_in;
         last_tone_ff <= tone;
         if (wrap) begin
            frame_ff <= frame_in;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit && wrap && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && wrap && emit) begin
         rsp_byte_ff <= frame_ff[acud_pkg::BYTE_BITS+1:2];
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_byte        = rsp_byte_ff;

endmodule

// ===== rtl/acud_checker.sv =====
// Port-level checker of the AFSK demodulator, bound to its top level.
// Depends on acud_pkg and the assertion macros header.
`include "afsk_correlator_uart_demodulator_assert.svh"

module acud_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [acud_pkg::BYTE_BITS-1:0] rsp_byte
);
   // A stalled byte stays offered and unchanged.
   `ACUD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp beat dropped while stalled")
   `ACUD_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_byte), "rsp byte changed while stalled")

   // One sample at a time: no ready right after an accepted beat.
   `ACUD_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "sample accepted while busy")

   // A new byte appears only as the sample that made it retires.
   `ACUD_ASSERT_SAME(a_byte_at_retire, $rose(rsp_valid), req_ready, "byte raised while still working")

endmodule

bind afsk_correlator_uart_demodulator acud_checker u_acud_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_byte  (rsp_if.rx_byte)
);

// ===== test/afsk_correlator_uart_demodulator_tb.sv =====
// Self-checking testbench of the AFSK correlator demodulator: drives tone-coded
// start/stop frames and noise, predicts every received byte and checks each rsp beat.
// Depends on acud_pkg and the acud_sample_if and acud_byte_if stream interfaces.
module afsk_correlator_uart_demodulator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Widths taken from the package.
   localparam int SAMPLE_W = acud_pkg::SAMPLE_BITS_DEF;
   localparam int BYTE_W   = acud_pkg::BYTE_BITS;
   localparam int DATA_W   = acud_pkg::CSR_DATA_BITS;
   localparam int PHASE_W  = acud_pkg::PHASE_BITS;
   localparam int NUDGE_W  = acud_pkg::NUDGE_BITS;
   localparam int FRAME_W  = acud_pkg::FRAME_BITS;

   // Run control.
   localparam int SETTLE_CYCLES  = 80;
   localparam int END_CYCLES     = 120;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int MIN_SAMPLES    = 1600;

   // Predictor constants.
   localparam int     WIN_TAPS  = 8;
   localparam int     SUM_SHIFT = 15;
   localparam longint SUM_MAX   = 131071;
   localparam longint SUM_MIN   = -131072;
   localparam longint HALF_TURN = 32768;
   localparam longint FULL_TURN = 65536;
   localparam int REF_TAB [4][WIN_TAPS] = '{
      '{  2621,  1761, -19153, -18717,  20513,  18457, -2354, -2614 },
      '{     0,  8108,   8731, -25056, -23608,  10119,  7956,  -193 },
      '{  2621,  6459,   4467, -14014, -28458, -20391, -4965,    97 },
      '{     0,  5207,  20569,  27960,  12973,  -5223, -6647, -2620 }
   };

   // Tone generator constants.
   localparam real MARK_HZ   = 4762.0;
   localparam real SPACE_HZ  = 2381.0;
   localparam real SAMPLE_HZ = 22050.0;
   localparam real TWO_PI    = 6.283185307179586;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   acud_pkg::csr_reg_type csr_index;
   logic [DATA_W-1:0]     csr_wdata;
   logic                  rsp_ready_q = 1'b0;

   acud_sample_if req_ch ();
   acud_byte_if   rsp_ch ();

   assign rsp_ch.ready = rsp_ready_q;

   afsk_correlator_uart_demodulator dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor state and register copies.
   logic signed [SAMPLE_W-1:0] win [WIN_TAPS];
   logic [1:0]         tone_hist;
   logic [PHASE_W-1:0] clk_phase;
   logic               last_tone;
   logic [FRAME_W-1:0] frame_sr;
   logic [PHASE_W-1:0] cfg_inc;
   logic [NUDGE_W-1:0] cfg_nudge;

   logic [BYTE_W-1:0] expected_bytes [$];
   int  samples_sent   = 0;
   int  bytes_received = 0;
   int  mismatches     = 0;
   int  rsp_stall      = 0;
   int  idle_cycles    = 0;
   bit  gaps_enabled   = 1'b1;

   // Tone generator state.
   real osc_turns = 0.0;
   int  tx_timer  = 0;
   int  tone_amp  = 16000;
   int  tone_noise = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Most gaps are short; one in sixteen is long and may outlast the block's processing time.
   function automatic int pick_gap();
      if ($urandom_range(0, 15) == 0) begin
         return $urandom_range(20, 70);
      end
      return $urandom_range(1, 4);
   endfunction

   // Predictor
   task automatic demod_reset();
      for (int i = 0; i < WIN_TAPS; i++) begin
         win[i] = '0;
      end
      tone_hist = '0;
      clk_phase = '0;
      last_tone = 1'b0;
      frame_sr  = '0;
      cfg_inc   = acud_pkg::PHASE_INC_RESET;
      cfg_nudge = acud_pkg::PHASE_NUDGE_RESET;
   endtask

   // Windowed correlation, floored to Q3.15 and saturated to 18 bits.
   function automatic longint correlate(input acud_pkg::corr_type ref_sel);
      longint acc;
      acc = 0;
      for (int i = 0; i < WIN_TAPS; i++) begin
         acc += longint'(win[i]) * longint'(REF_TAB[ref_sel][i]);
      end
      acc = acc >>> SUM_SHIFT;
      if (acc > SUM_MAX) begin
         acc = SUM_MAX;
      end
      if (acc < SUM_MIN) begin
         acc = SUM_MIN;
      end
      return acc;
   endfunction

   // Advances the model by one sample and queues the byte it completes, if any.
   task automatic demod_predict(input logic signed [SAMPLE_W-1:0] value);
      longint mi, mq, si, sq, diff, p;
      logic   tone;
      logic   data_bit;
      for (int i = 0; i < WIN_TAPS - 1; i++) begin
         win[i] = win[i+1];
      end
      win[WIN_TAPS-1] = value;

      mi = correlate(acud_pkg::CORR_MARK_COS);
      mq = correlate(acud_pkg::CORR_MARK_SIN);
      si = correlate(acud_pkg::CORR_SPACE_COS);
      sq = correlate(acud_pkg::CORR_SPACE_SIN);
      diff = mi * mi + mq * mq - si * si - sq * sq;
      tone = (diff > 0);
      tone_hist = {tone_hist[0], tone};

      // Pull the bit clock toward the tone edge, then advance it.
      p = longint'(clk_phase);
      if (tone_hist[0] ^ tone_hist[1]) begin
         if (p < HALF_TURN - longint'(cfg_inc >> 1)) begin
            p += longint'(cfg_nudge);
         end else begin
            p -= longint'(cfg_nudge);
         end
      end
      p += longint'(cfg_inc);

      if (p >= FULL_TURN || p < 0) begin
         clk_phase = p[PHASE_W-1:0];
         last_tone = tone;
         data_bit  = ~last_tone;
         if (data_bit) begin
            if (frame_sr[0] && !frame_sr[1]) begin
               expected_bytes.push_back(frame_sr[9:2]);
               frame_sr = acud_pkg::FRAME_TOP;
            end else begin
               frame_sr[10] = 1'b1;
            end
         end
         if (frame_sr[0]) begin
            frame_sr[1] = 1'b1;
         end
         frame_sr = frame_sr >> 1;
      end else begin
         clk_phase = p[PHASE_W-1:0];
      end
   endtask

   // Sends one sample beat after an optional gap; valid stays high afterwards.
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
      int gap;
      gap = 0;
      if (gaps_enabled && $urandom_range(0, 1) == 1) begin
         gap = pick_gap();
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.sample <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      demod_predict(value);
      samples_sent++;
   endtask

   // Emits the samples of one bit period at the tone that codes the data bit.
   task automatic send_tone_bit(input logic data_bit);
      real level;
      int  s;
      int  step;
      step = (cfg_inc >= 16'd4000) ? int'(cfg_inc) : int'(acud_pkg::PHASE_INC_RESET);
      do begin
         osc_turns += (data_bit ? SPACE_HZ : MARK_HZ) / SAMPLE_HZ;
         if (osc_turns >= 1.0) begin
            osc_turns -= 1.0;
         end
         level = real'(tone_amp) * $sin(TWO_PI * osc_turns);
         s = int'(level) + int'($urandom_range(0, 2 * tone_noise)) - tone_noise;
         if (s > 32767) begin
            s = 32767;
         end
         if (s < -32768) begin
            s = -32768;
         end
         send_sample(s[SAMPLE_W-1:0]);
         tx_timer += step;
      end while (tx_timer < FULL_TURN);
      tx_timer -= FULL_TURN;
   endtask

   // Idle line, start bit, eight data bits LSB first and a stop bit.
   task automatic send_frame(input logic [BYTE_W-1:0] data, input bit good_stop);
      int idle_bits;
      tone_amp   = $urandom_range(3000, 40000);
      tone_noise = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6000)
                                               : $urandom_range(0, 800);
      idle_bits  = $urandom_range(1, 3);
      repeat (idle_bits) send_tone_bit(1'b1);
      send_tone_bit(1'b0);
      for (int i = 0; i < BYTE_W; i++) begin
         send_tone_bit(data[i]);
      end
      send_tone_bit(good_stop ? 1'b1 : 1'b0);
   endtask

   // Mostly well-formed frames, with noise bursts and frames that break the stop bit.
   task automatic send_mixed(input int count);
      int target;
      int kind;
      int burst;
      target = samples_sent + count;
      while (samples_sent < target) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            burst = $urandom_range(1, 8);
            repeat (burst) send_sample(SAMPLE_W'($urandom()));
         end else if (kind == 1) begin
            send_frame(BYTE_W'($urandom()), 1'b0);
         end else begin
            send_frame(BYTE_W'($urandom()), 1'b1);
         end
      end
   endtask

   // Lowers valid, waits for every expected byte and lets the block run dry.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input acud_pkg::csr_reg_type idx, input logic [DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         acud_pkg::REG_PHASE_INC:   cfg_inc   = data;
         acud_pkg::REG_PHASE_NUDGE: cfg_nudge = data[NUDGE_W-1:0];
         default: ;
      endcase
   endtask

   // Test: full-scale, zero and bit-pattern samples.
   task automatic test_sample_extremes();
      logic signed [SAMPLE_W-1:0] pattern [9];
      pattern = '{16'sh7FFF, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh0001,
                  16'sh5555, -16'sh5556, 16'sh7FFF, 16'sh7FFF};
      foreach (pattern[i]) begin
         send_sample(pattern[i]);
      end
      for (int i = 0; i < 8; i++) begin
         send_sample((i % 2 == 0) ? 16'sh7FFF : -16'sh8000);
      end
      repeat (4) send_sample(16'sh0000);
   endtask

   // Test: back-to-back frames at the reset rate with no gaps on either side.
   task automatic test_frames_no_gaps();
      gaps_enabled = 1'b0;
      send_frame(8'h00, 1'b1);
      send_frame(8'hFF, 1'b1);
      send_frame(8'hA5, 1'b1);
      send_frame(BYTE_W'($urandom()), 1'b1);
      send_frame(BYTE_W'($urandom()), 1'b1);
      settle();
      gaps_enabled = 1'b1;
   endtask

   // Test: register extremes, including a stopped bit clock and nudging alone.
   task automatic test_register_extremes();
      write_reg(acud_pkg::REG_PHASE_INC, 16'hFFFF);
      write_reg(acud_pkg::REG_PHASE_NUDGE, 16'hFFFF);
      send_mixed(60);
      settle();
      write_reg(acud_pkg::REG_PHASE_INC, 16'd0);
      write_reg(acud_pkg::REG_PHASE_NUDGE, 16'd0);
      send_mixed(30);
      settle();
      write_reg(acud_pkg::REG_PHASE_NUDGE, 16'h7FFF);
      send_mixed(60);
      settle();
      write_reg(acud_pkg::REG_PHASE_INC, 16'd1);
      write_reg(acud_pkg::REG_PHASE_NUDGE, 16'd1);
      send_mixed(40);
      settle();
      write_reg(acud_pkg::REG_PHASE_INC, 16'd16384);
      write_reg(acud_pkg::REG_PHASE_NUDGE, 16'd0);
      send_mixed(150);
      settle();
   endtask

   // Test: random register settings, mostly at usable bit rates.
   task automatic test_random_traffic();
      while (samples_sent < MIN_SAMPLES) begin
         if ($urandom_range(0, 3) == 0) begin
            write_reg(acud_pkg::REG_PHASE_INC, DATA_W'($urandom_range(1, 65535)));
            write_reg(acud_pkg::REG_PHASE_NUDGE, DATA_W'($urandom_range(0, 65535)));
         end else begin
            write_reg(acud_pkg::REG_PHASE_INC, DATA_W'($urandom_range(9000, 20000)));
            write_reg(acud_pkg::REG_PHASE_NUDGE, DATA_W'($urandom_range(0, 4000)));
         end
         send_mixed(250);
         settle();
      end
   endtask

   // Receiver: random stalls and a check of every rsp beat.
   always @(posedge clock) begin
      logic [BYTE_W-1:0] want;
      if (!reset && rsp_ch.valid && rsp_ready_q) begin
         if (expected_bytes.size() == 0) begin
            $error("rx_byte: expected none, actual 0x%02h", rsp_ch.rx_byte);
            mismatches++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_ch.rx_byte !== want) begin
               $error("rx_byte: expected 0x%02h, actual 0x%02h", want, rsp_ch.rx_byte);
               mismatches++;
            end
            bytes_received++;
         end
      end
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready_q <= 1'b0;
      end else begin
         rsp_ready_q <= 1'b1;
         if (gaps_enabled && $urandom_range(0, 3) == 0) begin
            rsp_stall = pick_gap();
         end
      end
   end

   // Watchdog on cycles without any beat.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ready_q)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $error("watchdog: no beat for %0d cycles", idle_cycles);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset         <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.sample <= '0;
      csr_we        <= 1'b0;
      csr_index     <= acud_pkg::REG_PHASE_INC;
      csr_wdata     <= '0;
      demod_reset();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_sample_extremes();
      test_frames_no_gaps();
      test_register_extremes();
      test_random_traffic();

      req_ch.valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== afsk_correlator_uart_demodulator.f =====
+incdir+rtl
rtl/acud_pkg.sv
rtl/acud_sample_if.sv
rtl/acud_byte_if.sv
rtl/acud_ctrl.sv
rtl/acud_datapath.sv
rtl/afsk_correlator_uart_demodulator.sv
rtl/acud_checker.sv
test/afsk_correlator_uart_demodulator_tb.sv
